### rtl/core/lhw_pkg.sv
`timescale 1ns / 1ps

package lhw_pkg;

    localparam int STALL_MULT_DEF = 4;

    localparam int TIME_W   = 32;
    localparam int RTT_W    = 16;
    localparam int IP_W     = 32;
    localparam int CNT_W    = 32;
    localparam int LOSS_W   = 14;
    localparam int ACT_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [ACT_W-1:0] ACT_REPLY   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REPORT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PING_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REBOOT_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REBOOT_ENABLE = 2'd2;

    localparam logic [TIME_W-1:0] PING_INTERVAL_RST = 32'd1000;
    localparam logic [TIME_W-1:0] REBOOT_WINDOW_RST = 32'd60000;
    localparam logic              REBOOT_ENABLE_RST = 1'b1;

    // loss = timeouts * 10000 / (replies + timeouts)
    localparam logic [LOSS_W-1:0] LOSS_SCALE = 14'd10000;
    localparam int PROD_W = CNT_W + LOSS_W;

    // shared divider: remainder holds a 33-bit divisor range
    localparam int DIV_REM_W = CNT_W + 1;
    localparam int DIV_DVD_W = CNT_W;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] LOSS_STEPS = DIV_CNT_W'(LOSS_W);
    localparam logic [DIV_CNT_W-1:0] RTT_STEPS  = DIV_CNT_W'(DIV_DVD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOSS_GO,
        ST_LOSS_WAIT,
        ST_RTT_GO,
        ST_RTT_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] ping_interval_ms;
        logic [TIME_W-1:0] reboot_window_ms;
        logic              reboot_enable;
    } cfg_t;

    typedef struct packed {
        logic              reboot;
        logic              start_session;
        logic              stall_credit;
        logic              loss_valid;
        logic [LOSS_W-1:0] loss_hundredths;
        logic              rtt_valid;
        logic [RTT_W-1:0]  rtt_mean_ms;
    } res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### rtl/core/lhw_if.sv
`timescale 1ns / 1ps

interface lhw_in_if;
    logic                         valid;
    logic                         ready;
    logic [lhw_pkg::ACT_W-1:0]    action;
    logic [lhw_pkg::TIME_W-1:0]   now_ms;
    logic [lhw_pkg::RTT_W-1:0]    rtt_ms;
    logic                         link_up;
    logic [lhw_pkg::IP_W-1:0]     target_ip;

    modport source (output valid, action, now_ms, rtt_ms, link_up, target_ip, input ready);
    modport sink   (input valid, action, now_ms, rtt_ms, link_up, target_ip, output ready);
endinterface

interface lhw_out_if;
    logic                         valid;
    logic                         ready;
    logic                         reboot;
    logic                         start_session;
    logic                         stall_credit;
    logic                         loss_valid;
    logic [lhw_pkg::LOSS_W-1:0]   loss_hundredths;
    logic                         rtt_valid;
    logic [lhw_pkg::RTT_W-1:0]    rtt_mean_ms;

    modport source (output valid, reboot, start_session, stall_credit, loss_valid,
                    loss_hundredths, rtt_valid, rtt_mean_ms, input ready);
    modport sink   (input valid, reboot, start_session, stall_credit, loss_valid,
                    loss_hundredths, rtt_valid, rtt_mean_ms, output ready);
endinterface

interface lhw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lhw_pkg::CFG_IDX_W-1:0]   index;
    logic [lhw_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/lhw_cfg_regs.sv
`timescale 1ns / 1ps

module lhw_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    lhw_cfg_if.sink       cfg,
    output lhw_pkg::cfg_t regs
);

    lhw_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ping_interval_ms <= lhw_pkg::PING_INTERVAL_RST;
            regs_reg.reboot_window_ms <= lhw_pkg::REBOOT_WINDOW_RST;
            regs_reg.reboot_enable    <= lhw_pkg::REBOOT_ENABLE_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == lhw_pkg::REG_PING_INTERVAL)
                regs_reg.ping_interval_ms <= cfg.data;
            if (cfg.index == lhw_pkg::REG_REBOOT_WINDOW)
                regs_reg.reboot_window_ms <= cfg.data;
            if (cfg.index == lhw_pkg::REG_REBOOT_ENABLE)
                regs_reg.reboot_enable <= cfg.data[0];
        end
    end

endmodule

### rtl/core/lhw_divider.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module lhw_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lhw_pkg::DIV_REM_W-1:0]     rem_init,
    input  logic [lhw_pkg::DIV_DVD_W-1:0]     dividend,
    input  logic [lhw_pkg::DIV_REM_W-1:0]     divisor,
    input  logic [lhw_pkg::DIV_CNT_W-1:0]     steps,
    output logic [lhw_pkg::DIV_DVD_W-1:0]     quotient,
    output lhw_pkg::div_status_t              status
);

    localparam int SH_W = lhw_pkg::DIV_REM_W + 1;

    logic [lhw_pkg::DIV_REM_W-1:0] rem_reg;
    logic [lhw_pkg::DIV_DVD_W-1:0] dvd_reg;
    logic [lhw_pkg::DIV_REM_W-1:0] dsr_reg;
    logic [lhw_pkg::DIV_DVD_W-1:0] quo_reg;
    logic [lhw_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [lhw_pkg::DIV_CNT_W-1:0] cnt_next;
    logic                          done_reg;
    logic                          done_next;

    logic [SH_W-1:0] shifted;
    logic [SH_W-1:0] diff;
    logic            fits;

    assign shifted = {rem_reg, dvd_reg[lhw_pkg::DIV_DVD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
            cnt_next = steps;
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == lhw_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[lhw_pkg::DIV_REM_W-1:0] : shifted[lhw_pkg::DIV_REM_W-1:0];
            dvd_reg <= {dvd_reg[lhw_pkg::DIV_DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[lhw_pkg::DIV_DVD_W-2:0], fits};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

### rtl/core/link_heartbeat_watchdog_core.sv
`timescale 1ns / 1ps

// Heartbeat watchdog core.
// item: one timestamped event word (reply, timeout, service tick, stats report).
// result: exactly one word per item; tick flags on ticks, loss and mean RTT on
// reports, all zero otherwise.
// cfg: register writes (0 ping interval, 1 reboot window, 2 reboot enable),
// always ready; write only while the core is idle.
// One item at a time: item.ready is high only in the idle state.
// A reply, timeout or tick passes the execute and done states before its result
// is registered; the core returns to idle as the result turns valid.
// A report runs the shared divider up to twice, 14 steps for the loss and 32 for
// the mean RTT; the loss division runs when any reply or timeout was counted,
// the RTT division only when replies were counted.
// The result sits in an output register; while the receiver stalls, the core
// finishes the next item and waits in its final state for the slot.
// Reset clears all counters and timestamps and loads the register defaults.
module link_heartbeat_watchdog_core #(
    parameter int STALL_MULT = lhw_pkg::STALL_MULT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lhw_in_if.sink     item,
    lhw_out_if.source  result,
    lhw_cfg_if.sink    cfg
);

    localparam int LIM_W = lhw_pkg::TIME_W + $clog2(STALL_MULT + 1);

    lhw_pkg::cfg_t        regs;
    lhw_pkg::state_t      state_reg;
    lhw_pkg::state_t      state_next;
    lhw_pkg::div_status_t div_status;

    logic [lhw_pkg::ACT_W-1:0]  act_reg;
    logic [lhw_pkg::TIME_W-1:0] now_reg;
    logic [lhw_pkg::RTT_W-1:0]  rtt_reg;
    logic                       link_reg;
    logic [lhw_pkg::IP_W-1:0]   target_reg;

    logic [lhw_pkg::TIME_W-1:0] last_reply_reg;
    logic [lhw_pkg::TIME_W-1:0] last_tick_reg;
    logic [lhw_pkg::IP_W-1:0]   watched_ip_reg;
    logic                       session_reg;
    logic                       armed_reg;
    logic [lhw_pkg::CNT_W-1:0]  reply_cnt_reg;
    logic [lhw_pkg::CNT_W-1:0]  timeout_cnt_reg;
    logic [lhw_pkg::CNT_W-1:0]  rtt_total_reg;

    logic [lhw_pkg::PROD_W-1:0]    prod_reg;
    logic [lhw_pkg::DIV_REM_W-1:0] total_reg;
    lhw_pkg::res_t                 res_reg;
    lhw_pkg::res_t                 out_reg;
    logic                          out_valid_reg;

    logic                          accept;
    logic                          out_free;
    logic [lhw_pkg::DIV_REM_W-1:0] total;
    logic [LIM_W-1:0]              limit;
    logic [lhw_pkg::TIME_W-1:0]    gap;
    logic [lhw_pkg::TIME_W-1:0]    since;
    logic                          stall;
    logic                          tick_act;
    logic                          tick_bad;
    logic                          tick_new;
    logic                          expire;

    logic                          div_start;
    logic [lhw_pkg::DIV_REM_W-1:0] div_rem_init;
    logic [lhw_pkg::DIV_DVD_W-1:0] div_dividend;
    logic [lhw_pkg::DIV_REM_W-1:0] div_divisor;
    logic [lhw_pkg::DIV_CNT_W-1:0] div_steps;
    logic [lhw_pkg::DIV_DVD_W-1:0] div_quotient;

    lhw_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lhw_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign total    = {1'b0, reply_cnt_reg} + {1'b0, timeout_cnt_reg};

    // tick evaluation
    assign tick_act = (act_reg == lhw_pkg::ACT_TICK);
    assign limit    = LIM_W'(regs.ping_interval_ms) * LIM_W'(STALL_MULT);
    assign gap      = now_reg - last_tick_reg;
    assign stall    = (last_tick_reg != '0) && (LIM_W'(gap) > limit);
    assign tick_bad = !link_reg || (target_reg == '0);
    assign tick_new = !tick_bad && (!session_reg || (target_reg != watched_ip_reg));
    // a stall credit moves last reply to now, so the window cannot expire then
    assign since    = now_reg - last_reply_reg;
    assign expire   = !tick_bad && !tick_new && armed_reg && !stall
                      && (since > regs.reboot_window_ms);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lhw_pkg::ST_IDLE:
                if (accept)
                    state_next = lhw_pkg::ST_EXEC;
            lhw_pkg::ST_EXEC:
                if (act_reg != lhw_pkg::ACT_REPORT)
                    state_next = lhw_pkg::ST_DONE;
                else if (total != '0)
                    state_next = lhw_pkg::ST_LOSS_GO;
                else if (reply_cnt_reg != '0)
                    state_next = lhw_pkg::ST_RTT_GO;
                else
                    state_next = lhw_pkg::ST_DONE;
            lhw_pkg::ST_LOSS_GO:
                state_next = lhw_pkg::ST_LOSS_WAIT;
            lhw_pkg::ST_LOSS_WAIT:
                if (div_status.done)
                    state_next = (reply_cnt_reg != '0) ? lhw_pkg::ST_RTT_GO : lhw_pkg::ST_DONE;
            lhw_pkg::ST_RTT_GO:
                state_next = lhw_pkg::ST_RTT_WAIT;
            lhw_pkg::ST_RTT_WAIT:
                if (div_status.done)
                    state_next = lhw_pkg::ST_DONE;
            lhw_pkg::ST_DONE:
                if (out_free)
                    state_next = lhw_pkg::ST_IDLE;
            default:
                state_next = lhw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        item.ready   = 1'b0;
        div_start    = 1'b0;
        div_rem_init = '0;
        div_dividend = '0;
        div_divisor  = '0;
        div_steps    = '0;
        unique case (state_reg)
            lhw_pkg::ST_IDLE:
                item.ready = 1'b1;
            lhw_pkg::ST_LOSS_GO:
            begin
                // quotient is below 2^14, so the top bits start as the remainder
                div_start    = 1'b1;
                div_rem_init = lhw_pkg::DIV_REM_W'(prod_reg[lhw_pkg::PROD_W-1:lhw_pkg::LOSS_W]);
                div_dividend = {prod_reg[lhw_pkg::LOSS_W-1:0],
                                {(lhw_pkg::DIV_DVD_W - lhw_pkg::LOSS_W){1'b0}}};
                div_divisor  = total_reg;
                div_steps    = lhw_pkg::LOSS_STEPS;
            end
            lhw_pkg::ST_RTT_GO:
            begin
                div_start    = 1'b1;
                div_dividend = rtt_total_reg;
                div_divisor  = {1'b0, reply_cnt_reg};
                div_steps    = lhw_pkg::RTT_STEPS;
            end
            lhw_pkg::ST_EXEC, lhw_pkg::ST_LOSS_WAIT, lhw_pkg::ST_RTT_WAIT, lhw_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lhw_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= item.action;
            now_reg    <= item.now_ms;
            rtt_reg    <= item.rtt_ms;
            link_reg   <= item.link_up;
            target_reg <= item.target_ip;
        end
        if (state_reg == lhw_pkg::ST_EXEC)
        begin
            prod_reg  <= lhw_pkg::PROD_W'(timeout_cnt_reg) * lhw_pkg::PROD_W'(lhw_pkg::LOSS_SCALE);
            total_reg <= total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reply_reg  <= '0;
            last_tick_reg   <= '0;
            watched_ip_reg  <= '0;
            session_reg     <= 1'b0;
            armed_reg       <= 1'b0;
            reply_cnt_reg   <= '0;
            timeout_cnt_reg <= '0;
            rtt_total_reg   <= '0;
        end
        else if (state_reg == lhw_pkg::ST_EXEC)
        begin
            unique case (act_reg)
                lhw_pkg::ACT_REPLY:
                begin
                    last_reply_reg <= now_reg;
                    reply_cnt_reg  <= reply_cnt_reg + 1'b1;
                    rtt_total_reg  <= rtt_total_reg + lhw_pkg::CNT_W'(rtt_reg);
                    armed_reg      <= 1'b1;
                end
                lhw_pkg::ACT_TIMEOUT:
                    timeout_cnt_reg <= timeout_cnt_reg + 1'b1;
                lhw_pkg::ACT_TICK:
                begin
                    last_tick_reg <= now_reg;
                    if (stall || tick_bad || tick_new || (expire && !regs.reboot_enable))
                        last_reply_reg <= now_reg;
                    if (tick_new)
                    begin
                        armed_reg      <= 1'b0;
                        session_reg    <= 1'b1;
                        watched_ip_reg <= target_reg;
                    end
                end
                lhw_pkg::ACT_REPORT:
                begin
                end
                default:
                begin
                end
            endcase
        end
        else if ((state_reg == lhw_pkg::ST_DONE) && out_free && (act_reg == lhw_pkg::ACT_REPORT))
        begin
            reply_cnt_reg   <= '0;
            timeout_cnt_reg <= '0;
            rtt_total_reg   <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lhw_pkg::ST_EXEC)
        begin
            res_reg.reboot          <= tick_act && expire && regs.reboot_enable;
            res_reg.start_session   <= tick_act && tick_new;
            res_reg.stall_credit    <= tick_act && stall;
            res_reg.loss_valid      <= 1'b0;
            res_reg.loss_hundredths <= '0;
            res_reg.rtt_valid       <= 1'b0;
            res_reg.rtt_mean_ms     <= '0;
        end
        else if ((state_reg == lhw_pkg::ST_LOSS_WAIT) && div_status.done)
        begin
            res_reg.loss_valid      <= 1'b1;
            res_reg.loss_hundredths <= div_quotient[lhw_pkg::LOSS_W-1:0];
        end
        else if ((state_reg == lhw_pkg::ST_RTT_WAIT) && div_status.done)
        begin
            res_reg.rtt_valid   <= 1'b1;
            res_reg.rtt_mean_ms <= div_quotient[lhw_pkg::RTT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == lhw_pkg::ST_DONE) && out_free)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == lhw_pkg::ST_DONE) && out_free)
            out_reg <= res_reg;
    end

    assign result.valid           = out_valid_reg;
    assign result.reboot          = out_reg.reboot;
    assign result.start_session   = out_reg.start_session;
    assign result.stall_credit    = out_reg.stall_credit;
    assign result.loss_valid      = out_reg.loss_valid;
    assign result.loss_hundredths = out_reg.loss_hundredths;
    assign result.rtt_valid       = out_reg.rtt_valid;
    assign result.rtt_mean_ms     = out_reg.rtt_mean_ms;

endmodule
